// ----- hdl/ipbd_pkg.sv -----
// ----------------------------------------------------------------------------
// ipbd_pkg: shared types and constants for the blower drive controller
// Word types for both channels, register indexes, limit codes and the
// target voltage tables (unsigned Q3.16, rounded to nearest).
// ----------------------------------------------------------------------------
package ipbd_pkg;

	// Input word: one control tick
	typedef struct packed {
		logic [11:0] flow_sample;
		logic [11:0] pressure_sample;
		logic        assist_start;
	} in_word_t;

	// Output word: DAC code and clamp status
	typedef struct packed {
		logic [7:0] drive_code;
		logic [1:0] limit_state;
	} out_word_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TENTHS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KP_FLOW       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD_FLOW       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KP_PRESSURE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KD_PRESSURE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd7;

	// Register reset values
	localparam logic       RST_MODE          = 1'b0;
	localparam logic [3:0] RST_TARGET_TENTHS = 4'd5;
	localparam logic [15:0] RST_KP           = 16'd32768;
	localparam logic [15:0] RST_KD           = 16'd786;
	localparam logic [15:0] RST_FLOOR        = 16'd9989;
	localparam logic [15:0] RST_CEILING      = 16'd63401;

	// Limit status codes
	localparam logic [1:0] LIMIT_NONE  = 2'd0;
	localparam logic [1:0] LIMIT_FLOOR = 2'd1;
	localparam logic [1:0] LIMIT_CEIL  = 2'd2;

	// Sensed voltage: (sample + offset, flow only) * 52.8, rounded, done as (x*528 + 5) / 10
	localparam logic [12:0] FLOW_OFFSET = 13'd2143;
	localparam logic [21:0] SENSE_ROUND = 22'd5;
	localparam logic [4:0]  SENSE_DIV   = 5'd10;

	// Flow mode target: 1.2*T + 2.1 volts, Q3.16
	function automatic logic [18:0] flow_target(input logic [3:0] tn);
		logic [18:0] v;
		unique case (tn)
			4'd0:    v = 19'd137626;
			4'd1:    v = 19'd145490;
			4'd2:    v = 19'd153354;
			4'd3:    v = 19'd161219;
			4'd4:    v = 19'd169083;
			4'd5:    v = 19'd176947;
			4'd6:    v = 19'd184812;
			4'd7:    v = 19'd192676;
			4'd8:    v = 19'd200540;
			4'd9:    v = 19'd208404;
			4'd10:   v = 19'd216269;
			4'd11:   v = 19'd224133;
			4'd12:   v = 19'd231997;
			4'd13:   v = 19'd239862;
			4'd14:   v = 19'd247726;
			default: v = 19'd255590;
		endcase
		return v;
	endfunction

	// Pressure mode target: 1.911*T + 1.389 volts, Q3.16
	function automatic logic [18:0] pressure_target(input logic [3:0] tn);
		logic [18:0] v;
		unique case (tn)
			4'd0:    v = 19'd91030;
			4'd1:    v = 19'd103553;
			4'd2:    v = 19'd116077;
			4'd3:    v = 19'd128601;
			4'd4:    v = 19'd141125;
			4'd5:    v = 19'd153649;
			4'd6:    v = 19'd166173;
			4'd7:    v = 19'd178697;
			4'd8:    v = 19'd191221;
			4'd9:    v = 19'd203745;
			4'd10:   v = 19'd216269;
			4'd11:   v = 19'd228793;
			4'd12:   v = 19'd241317;
			4'd13:   v = 19'd253841;
			4'd14:   v = 19'd266365;
			default: v = 19'd278888;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/incremental_pd_blower_drive.sv -----
// ----------------------------------------------------------------------------
// incremental_pd_blower_drive: incremental PD drive with clamp
// Takes one flow/pressure sample pair per word and returns one DAC code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one control tick per word.
//   Output channel out_valid/out_ready/out_data returns one word per input:
//   the clamped drive's integer part and whether floor or ceiling was hit.
//   Registers are written through cfg_wr_en/cfg_index/cfg_wdata; the user
//   must do so only while idle, as the block does not enforce it.
// Timing:
//   A new word is taken only after the last result is in the output register.
//   The sensed voltage is found by a divide-by-ten unit giving two quotient
//   bits a cycle, then the error, then the gain products by a shift-add unit
//   taking two gain bits a cycle, then the sum and the clamp.
// Reset:
//   arst_n clears the registers to their defaults, the last error to zero and
//   the last drive to the default floor.
// Stall:
//   While out_ready is low a finished word waits in the output register; the
//   next word is taken and worked on, and holds before the clamp stage until
//   the output register is free.
// ----------------------------------------------------------------------------
module incremental_pd_blower_drive
	import ipbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	// configuration writes
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned DIV_STEPS = 11;
	localparam int unsigned MAC_STEPS = 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ERR,
		S_MAC,
		S_SUM,
		S_DONE
	} state_t;

	// configuration registers
	logic        mode_q;
	logic [3:0]  target_tenths_q;
	logic [15:0] kp_flow_q, kd_flow_q, kp_pressure_q, kd_pressure_q;
	logic [15:0] drive_floor_q, drive_ceiling_q;

	// control and state
	state_t             state_q;
	logic [3:0]         cnt_q;
	logic               out_valid_q;
	out_word_t          out_data_q;
	logic signed [19:0] last_error_q;
	logic [23:0]        last_drive_q;

	// datapath
	logic [21:0]        quo_q;
	logic [3:0]         rem_q;
	logic               start_q;
	logic signed [19:0] err_q;
	logic signed [20:0] derr_q;
	logic [15:0]        kp_sh_q, kd_sh_q;
	logic signed [23:0] acc_q;
	logic signed [25:0] check_q;

	logic               in_fire;
	logic               out_load;
	logic [12:0]        sample_sum;
	logic [21:0]        dividend;
	logic [21:0]        quo_next;
	logic [3:0]         rem_next;
	logic [18:0]        target;
	logic signed [19:0] err_next;
	logic signed [20:0] derr_next;
	logic signed [23:0] mac_sum;
	logic [23:0]        prev_drive;
	logic signed [23:0] delta;
	logic signed [25:0] lo_ext, hi_ext;
	logic [23:0]        clamped;
	logic [1:0]         limit;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// digit times operand: 0, 1, 2 or 3 times a sign-extended value
	function automatic logic signed [23:0] digit_mul(input logic [1:0] d,
			input logic signed [20:0] v);
		logic signed [23:0] e;
		logic signed [23:0] r;
		e = {{3{v[20]}}, v};
		case (d)
			2'd0:    r = '0;
			2'd1:    r = e;
			2'd2:    r = e <<< 1;
			default: r = e + (e <<< 1);
		endcase
		return r;
	endfunction

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= RST_MODE;
			target_tenths_q <= RST_TARGET_TENTHS;
			kp_flow_q       <= RST_KP;
			kd_flow_q       <= RST_KD;
			kp_pressure_q   <= RST_KP;
			kd_pressure_q   <= RST_KD;
			drive_floor_q   <= RST_FLOOR;
			drive_ceiling_q <= RST_CEILING;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:          mode_q          <= cfg_wdata[0];
				REG_TARGET_TENTHS: target_tenths_q <= cfg_wdata[3:0];
				REG_KP_FLOW:       kp_flow_q       <= cfg_wdata;
				REG_KD_FLOW:       kd_flow_q       <= cfg_wdata;
				REG_KP_PRESSURE:   kp_pressure_q   <= cfg_wdata;
				REG_KD_PRESSURE:   kd_pressure_q   <= cfg_wdata;
				REG_DRIVE_FLOOR:   drive_floor_q   <= cfg_wdata;
				REG_DRIVE_CEILING: drive_ceiling_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// dividend for the sensed voltage: sum*528 + 5
	always_comb begin
		if (mode_q)
			sample_sum = {1'b0, in_data.pressure_sample};
		else
			sample_sum = {1'b0, in_data.flow_sample} + FLOW_OFFSET;
		dividend = {sample_sum, 9'b0} + {5'b0, sample_sum, 4'b0} + SENSE_ROUND;
	end

	// divide by ten, two quotient bits a step, MSB first
	always_comb begin
		logic [4:0] t;
		logic [21:0] q;
		logic [3:0] r;
		q = quo_q;
		r = rem_q;
		for (int j = 0; j < 2; j++) begin
			t = {r, q[21]};
			q = {q[20:0], 1'b0};
			if (t >= SENSE_DIV) begin
				t    = t - SENSE_DIV;
				q[0] = 1'b1;
			end
			r = t[3:0];
		end
		quo_next = q;
		rem_next = r;
	end

	// error and its change
	always_comb begin
		target    = mode_q ? pressure_target(target_tenths_q)
		                   : flow_target(target_tenths_q);
		err_next  = $signed({1'b0, target}) - $signed({1'b0, quo_q[18:0]});
		derr_next = {err_next[19], err_next} - {last_error_q[19], last_error_q};
	end

	// shift-add step: floor((acc + dp*err + dd*derr) / 4)
	always_comb begin
		mac_sum = acc_q + digit_mul(kp_sh_q[1:0], {err_q[19], err_q})
		        + digit_mul(kd_sh_q[1:0], derr_q);
	end

	// previous drive plus increment, or the floor with no increment on assist start; the drive itself is unsigned
	always_comb begin
		prev_drive = start_q ? {drive_floor_q, 8'b0} : last_drive_q;
		delta      = start_q ? '0 : acc_q;
	end

	// clamp to floor, then ceiling
	always_comb begin
		lo_ext = $signed({2'b0, drive_floor_q, 8'b0});
		hi_ext = $signed({2'b0, drive_ceiling_q, 8'b0});
		if (check_q < lo_ext) begin
			clamped = {drive_floor_q, 8'b0};
			limit   = LIMIT_FLOOR;
		end else if (check_q > hi_ext) begin
			clamped = {drive_ceiling_q, 8'b0};
			limit   = LIMIT_CEIL;
		end else begin
			clamped = check_q[23:0];
			limit   = LIMIT_NONE;
		end
	end

	// sequencer, output register and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			last_error_q <= '0;
			last_drive_q <= {RST_FLOOR, 8'b0};
		end else begin
			if (out_valid_q && out_ready && !out_load)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					if (cnt_q == 4'(DIV_STEPS - 1)) begin
						state_q <= S_ERR;
					end
					cnt_q <= cnt_q + 4'd1;
				end
				S_ERR: begin
					state_q <= S_MAC;
					cnt_q   <= '0;
				end
				S_MAC: begin
					if (cnt_q == 4'(MAC_STEPS - 1)) begin
						state_q <= S_SUM;
					end
					cnt_q <= cnt_q + 4'd1;
				end
				S_SUM: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q            <= 1'b1;
						out_data_q.drive_code  <= clamped[23:16];
						out_data_q.limit_state <= limit;
						last_drive_q           <= clamped;
						last_error_q           <= err_q;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					quo_q   <= dividend;
					rem_q   <= '0;
					start_q <= in_data.assist_start;
				end
			end
			S_DIV: begin
				quo_q <= quo_next;
				rem_q <= rem_next;
			end
			S_ERR: begin
				err_q   <= err_next;
				derr_q  <= derr_next;
				acc_q   <= '0;
				kp_sh_q <= mode_q ? kp_pressure_q : kp_flow_q;
				kd_sh_q <= mode_q ? kd_pressure_q : kd_flow_q;
			end
			S_MAC: begin
				acc_q   <= mac_sum >>> 2;
				kp_sh_q <= {2'b0, kp_sh_q[15:2]};
				kd_sh_q <= {2'b0, kd_sh_q[15:2]};
			end
			S_SUM: begin
				check_q <= {2'b0, prev_drive} + {{2{delta[23]}}, delta};
			end
			default: ;
		endcase
	end

endmodule
